@@ rtl/tmp_pkg.sv @@
package tmp_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TICKS_W = 24;
  localparam int unsigned DUTY_W  = 21;
  localparam int unsigned PULSE_W = 11;
  localparam int unsigned MIX_W   = 10;
  localparam int unsigned MAG_W   = 9;
  localparam int unsigned DELTA_W = 7;
  localparam int unsigned OP_W    = 32;
  localparam int unsigned PROD_W  = 2 * OP_W;

  // frame layout
  localparam int unsigned NUM_STICKS = 4;
  localparam int unsigned POS_W      = 3;

  // pulse constants in microseconds
  localparam logic [PULSE_W-1:0] NEUTRAL_US = 11'd1500;

  // three-stick mix: floor(a * 200 / 768) == (a * MIX3_K) >> MIX3_SH for a <= 384
  localparam logic [19:0] MIX3_K  = 20'd546150;
  localparam int unsigned MIX3_SH = 21;

  // vertical mix: floor(a * 200 / 256) == (a * VERT_K) >> VERT_SH
  localparam logic [4:0]  VERT_K  = 5'd25;
  localparam int unsigned VERT_SH = 5;

  // ticks: floor(p / 20000) == ((p >> 5) * RECIP_M) >> RECIP_SH for p < 2^35
  localparam int unsigned PRE_SH   = 5;
  localparam int unsigned TICK_P_W = 35;
  localparam logic [30:0] RECIP_M  = 31'd1759218605;
  localparam int unsigned RECIP_SH = 40;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 24'd600000;

  // channel codes, in mixing order
  localparam int unsigned CH_W = 3;
  localparam logic [CH_W-1:0] CH_FR   = 3'd0;
  localparam logic [CH_W-1:0] CH_FL   = 3'd1;
  localparam logic [CH_W-1:0] CH_BR   = 3'd2;
  localparam logic [CH_W-1:0] CH_BL   = 3'd3;
  localparam logic [CH_W-1:0] CH_VERT = 3'd4;
  localparam int unsigned NUM_CH = 5;

  // stored stick values of the current frame
  typedef struct packed {
    logic signed [BYTE_W-1:0] lx;
    logic signed [BYTE_W-1:0] ly;
    logic signed [BYTE_W-1:0] rx;
    logic signed [BYTE_W-1:0] ry;
  } tmp_sticks_t;

endpackage

@@ rtl/tmp_frame.sv @@
module tmp_frame import tmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output tmp_sticks_t       sticks,
  output logic              armed
);

  logic [POS_W-1:0]  pos_r;
  logic [BYTE_W-1:0] stick_r [NUM_STICKS];
  logic              armed_r;

  // byte slot counter, button check and stick store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      armed_r <= 1'b0;
      for (int i = 0; i < NUM_STICKS; i++) begin
        stick_r[i] <= '0;
      end
    end else if (accept) begin
      pos_r <= pos_r + 1'b1;
      if (!pos_r[POS_W-1]) begin
        if (rx_byte != '0) begin
          armed_r <= 1'b1;
        end
      end else begin
        stick_r[pos_r[POS_W-2:0]] <= rx_byte;
      end
    end
  end

  assign sticks.lx = stick_r[0];
  assign sticks.ly = stick_r[1];
  assign sticks.rx = stick_r[2];
  assign sticks.ry = stick_r[3];
  assign armed     = armed_r;

endmodule

@@ rtl/tmp_mul.sv @@
module tmp_mul import tmp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [OP_W-1:0]   op_a,
  input  logic [OP_W-1:0]   op_b,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  // shared unsigned multiplier, result registered and held when idle
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

@@ rtl/thruster_mixer_pwm.sv @@
// the five channels take three passes each through the one shared 32x32 multiplier
//   (mix scale, period scale, reciprocal of 20000)
// input stalls while an item is in work; a finished result may wait in the output register
// reset (synchronous, rst_n low): byte slot, sticks and armed flag cleared, period 600000
module thruster_mixer_pwm import tmp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TICKS_W-1:0] cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DUTY_W-1:0]  out_duty_front_right,
  output logic [DUTY_W-1:0]  out_duty_front_left,
  output logic [DUTY_W-1:0]  out_duty_back_right,
  output logic [DUTY_W-1:0]  out_duty_back_left,
  output logic [DUTY_W-1:0]  out_duty_front_vertical,
  output logic [DUTY_W-1:0]  out_duty_back_vertical,
  output logic               out_is_armed
);

  typedef enum logic [2:0] {
    IDLE,
    MAG,
    TICK,
    RECIP,
    WRAP
  } state_t;

  state_t              state_r;
  logic [CH_W-1:0]     ch_r;
  logic [TICKS_W-1:0]  tpp_r;
  logic [DUTY_W-1:0]   work_r [NUM_CH-1];
  logic [DUTY_W-1:0]   duty_r [NUM_CH];
  logic                out_valid_r;
  logic                out_armed_r;

  logic                accept;
  logic                out_free;
  tmp_sticks_t         sticks;
  logic                armed;
  logic signed [MIX_W-1:0] lx_w, ly_w, rx_w, ry_w;
  logic signed [MIX_W-1:0] mix_sum;
  logic [MIX_W-1:0]    mix_abs;
  logic [MAG_W-1:0]    mag;
  logic [DELTA_W-1:0]  delta;
  logic [PULSE_W-1:0]  pulse;
  logic                mul_en;
  logic [OP_W-1:0]     op_a, op_b;
  logic [PROD_W-1:0]   prod;
  logic [DUTY_W-1:0]   duty_new;
  logic [CH_W-2:0]     prev_ch;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  tmp_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .sticks  (sticks),
    .armed   (armed)
  );

  // signed mix of the selected channel
  assign lx_w = {{(MIX_W-BYTE_W){sticks.lx[BYTE_W-1]}}, sticks.lx};
  assign ly_w = {{(MIX_W-BYTE_W){sticks.ly[BYTE_W-1]}}, sticks.ly};
  assign rx_w = {{(MIX_W-BYTE_W){sticks.rx[BYTE_W-1]}}, sticks.rx};
  assign ry_w = {{(MIX_W-BYTE_W){sticks.ry[BYTE_W-1]}}, sticks.ry};

  always_comb begin
    case (ch_r)
      CH_FR:   mix_sum = ry_w - rx_w - lx_w;
      CH_FL:   mix_sum = ry_w + rx_w + lx_w;
      CH_BR:   mix_sum = ry_w + rx_w - lx_w;
      CH_BL:   mix_sum = ry_w - rx_w + lx_w;
      CH_VERT: mix_sum = ly_w;
      default: mix_sum = '0;
    endcase
  end

  // magnitude, the scaled result is given the sign back so division truncates to zero
  assign mix_abs = mix_sum[MIX_W-1] ? (MIX_W)'(-mix_sum) : (MIX_W)'(mix_sum);
  assign mag     = mix_abs[MAG_W-1:0];

  // scaled offset from the product of the mix pass
  assign delta = (ch_r == CH_VERT) ? prod[VERT_SH +: DELTA_W] : prod[MIX3_SH +: DELTA_W];

  always_comb begin
    if (!armed) begin
      pulse = NEUTRAL_US;
    end else if (mix_sum[MIX_W-1]) begin
      pulse = NEUTRAL_US - PULSE_W'(delta);
    end else begin
      pulse = NEUTRAL_US + PULSE_W'(delta);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    case (state_r)
      MAG: begin
        op_a = OP_W'(mag);
        op_b = (ch_r == CH_VERT) ? OP_W'(VERT_K) : OP_W'(MIX3_K);
      end
      TICK: begin
        op_a = OP_W'(tpp_r);
        op_b = OP_W'(pulse);
      end
      RECIP: begin
        op_a = OP_W'(prod[TICK_P_W-1:PRE_SH]);
        op_b = OP_W'(RECIP_M);
      end
      default: begin
        mul_en = 1'b0;
        op_a   = '0;
        op_b   = '0;
      end
    endcase
  end

  tmp_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign duty_new = prod[RECIP_SH +: DUTY_W];

  // slot of the channel finished in the previous pass
  assign prev_ch = ch_r[CH_W-2:0] - 1'b1;

  // period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r <= TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tpp_r <= cfg_data;
    end
  end

  // channel sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      ch_r        <= CH_FR;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == WRAP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (accept) begin
            ch_r    <= CH_FR;
            state_r <= MAG;
          end
        end
        MAG: begin
          // previous channel's duty is ready
          if (ch_r != CH_FR) begin
            work_r[prev_ch] <= duty_new;
          end
          state_r <= TICK;
        end
        TICK: begin
          state_r <= RECIP;
        end
        RECIP: begin
          if (ch_r == CH_VERT) begin
            state_r <= WRAP;
          end else begin
            ch_r    <= ch_r + 1'b1;
            state_r <= MAG;
          end
        end
        WRAP: begin
          if (out_free) begin
            for (int i = 0; i < NUM_CH - 1; i++) begin
              duty_r[i] <= work_r[i];
            end
            duty_r[NUM_CH-1] <= duty_new;
            out_armed_r      <= armed;
            state_r          <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_duty_front_right    = duty_r[CH_FR];
  assign out_duty_front_left     = duty_r[CH_FL];
  assign out_duty_back_right     = duty_r[CH_BR];
  assign out_duty_back_left      = duty_r[CH_BL];
  assign out_duty_front_vertical = duty_r[CH_VERT];
  assign out_duty_back_vertical  = duty_r[CH_VERT];
  assign out_is_armed            = out_armed_r;

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmp_pkg::*;

  // mixing and pulse constants, in microseconds
  localparam int NEUTRAL_PULSE = 1500;
  localparam int MIX_GAIN      = 200;
  localparam int MIX3_DIV      = 256 * 3;
  localparam int MIX1_DIV      = 256;
  localparam int PERIOD_US     = 20000;

  // byte slots within the eight-byte frame
  localparam logic [POS_W-1:0] FIRST_STICK_SLOT = 3'd4;
  localparam logic [POS_W-1:0] SLOT_LX          = 3'd4;
  localparam logic [POS_W-1:0] SLOT_LY          = 3'd5;
  localparam logic [POS_W-1:0] SLOT_RX          = 3'd6;
  localparam logic [POS_W-1:0] SLOT_RY          = 3'd7;

  localparam int DUT_LATENCY    = 17;
  localparam int NUM_PHASES     = 7;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLD_AT_ITEM   = 400;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic [DUTY_W-1:0] fr;
    logic [DUTY_W-1:0] fl;
    logic [DUTY_W-1:0] br;
    logic [DUTY_W-1:0] bl;
    logic [DUTY_W-1:0] fv;
    logic [DUTY_W-1:0] bv;
    logic              armed;
  } duty_set_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_rx_byte = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TICKS_W-1:0] cfg_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DUTY_W-1:0]  out_duty_front_right;
  logic [DUTY_W-1:0]  out_duty_front_left;
  logic [DUTY_W-1:0]  out_duty_back_right;
  logic [DUTY_W-1:0]  out_duty_back_left;
  logic [DUTY_W-1:0]  out_duty_front_vertical;
  logic [DUTY_W-1:0]  out_duty_back_vertical;
  logic               out_is_armed;

  // mirror of the block state
  logic [TICKS_W-1:0] period_ref = TICKS_RESET;
  logic [POS_W-1:0]   frame_slot = '0;
  tmp_sticks_t        sticks_ref = '0;
  logic               armed_ref = 1'b0;

  logic [BYTE_W-1:0]  byte_queue[$];
  duty_set_t          duty_expected[$];
  logic [POS_W-1:0]   fill_slot = '0;

  int  errors = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  input_stall_cycles = 0;
  int  settings_used = 1;
  logic quiet_phase = 1'b0;
  logic long_hold = 1'b0;
  logic hold_done = 1'b0;
  int  hold_left = 0;
  int  gap_left = 0;
  int  stall_left = 0;

  thruster_mixer_pwm u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_rx_byte              (in_rx_byte),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_data                (cfg_data),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_duty_front_right    (out_duty_front_right),
    .out_duty_front_left     (out_duty_front_left),
    .out_duty_back_right     (out_duty_back_right),
    .out_duty_back_left      (out_duty_back_left),
    .out_duty_front_vertical (out_duty_front_vertical),
    .out_duty_back_vertical  (out_duty_back_vertical),
    .out_is_armed            (out_is_armed)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // pulse width in us to pwm ticks, truncated
  function automatic logic [DUTY_W-1:0] pulse_ticks(int pulse);
    longint prod;
    prod = longint'(period_ref) * pulse;
    return DUTY_W'(prod / PERIOD_US);
  endfunction

  // update the mirrored state with one byte and queue the duties it yields
  function automatic void mix_byte(logic [BYTE_W-1:0] b);
    int lx, ly, rx, ry, vert;
    duty_set_t r;
    if (frame_slot < FIRST_STICK_SLOT) begin
      if (b != '0) armed_ref = 1'b1;
    end else begin
      case (frame_slot)
        SLOT_LX: sticks_ref.lx = b;
        SLOT_LY: sticks_ref.ly = b;
        SLOT_RX: sticks_ref.rx = b;
        SLOT_RY: sticks_ref.ry = b;
        default: ;
      endcase
    end
    frame_slot = frame_slot + 1'b1;
    lx = sticks_ref.lx;
    ly = sticks_ref.ly;
    rx = sticks_ref.rx;
    ry = sticks_ref.ry;
    if (armed_ref) begin
      r.fr = pulse_ticks(NEUTRAL_PULSE + (ry - rx - lx) * MIX_GAIN / MIX3_DIV);
      r.fl = pulse_ticks(NEUTRAL_PULSE + (ry + rx + lx) * MIX_GAIN / MIX3_DIV);
      r.br = pulse_ticks(NEUTRAL_PULSE + (ry + rx - lx) * MIX_GAIN / MIX3_DIV);
      r.bl = pulse_ticks(NEUTRAL_PULSE + (ry - rx + lx) * MIX_GAIN / MIX3_DIV);
      vert = NEUTRAL_PULSE + ly * MIX_GAIN / MIX1_DIV;
    end else begin
      r.fr = pulse_ticks(NEUTRAL_PULSE);
      r.fl = r.fr;
      r.br = r.fr;
      r.bl = r.fr;
      vert = NEUTRAL_PULSE;
    end
    r.fv = pulse_ticks(vert);
    r.bv = r.fv;
    r.armed = armed_ref;
    duty_expected.push_back(r);
  endfunction

  function automatic int field_ok(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
      return 0;
    end
    return 1;
  endfunction

  // idle length, mostly short with the odd long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: feeds bytes from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        mix_byte(in_rx_byte);
        items_sent++;
      end
      if (in_valid && in_stall) input_stall_cycles++;
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= byte_queue.pop_front();
          gap_left   = pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, while the sender keeps offering items
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      long_hold <= (hold_left > 1);
    end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
      hold_done <= 1'b1;
      hold_left = HOLD_CYCLES;
      long_hold <= 1'b1;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (quiet_phase) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_stall  <= 1'b0;
          stall_left = $urandom_range(0, 20);
        end
        9: begin
          out_stall  <= 1'b1;
          stall_left = $urandom_range(10, 40);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_left = $urandom_range(0, 3);
        end
      endcase
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    duty_set_t want;
    int good;
    if (rst_n && out_valid && !out_stall) begin
      if (duty_expected.size() == 0) begin
        $display("%0t: result with no item pending, expected none, actual fr %0d",
                 $time, out_duty_front_right);
        errors++;
      end else begin
        want = duty_expected.pop_front();
        good = field_ok("duty_front_right", want.fr, out_duty_front_right)
             & field_ok("duty_front_left", want.fl, out_duty_front_left)
             & field_ok("duty_back_right", want.br, out_duty_back_right)
             & field_ok("duty_back_left", want.bl, out_duty_back_left)
             & field_ok("duty_front_vertical", want.fv, out_duty_front_vertical)
             & field_ok("duty_back_vertical", want.bv, out_duty_back_vertical)
             & field_ok("is_armed", want.armed, out_is_armed);
        if (!good) errors++;
        results_checked++;
      end
    end
  end

  function automatic void push_byte(logic [BYTE_W-1:0] b);
    byte_queue.push_back(b);
    fill_slot = fill_slot + 1'b1;
  endfunction

  // random frame content, stick bytes leaning on the extremes
  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] corners[6] = '{8'h7F, 8'h80, 8'h00, 8'hFF, 8'h01, 8'h81};
    if (fill_slot < FIRST_STICK_SLOT)
      return ($urandom_range(0, 9) < 7) ? 8'h00 : BYTE_W'($urandom);
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 5)];
    return BYTE_W'($urandom);
  endfunction

  // checked between edges, once the driver and monitor have settled
  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid || duty_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_period(logic [TICKS_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    period_ref = value;
    settings_used++;
  endtask

  // stimulus
  initial begin
    logic [BYTE_W-1:0] directed_bytes[24] = '{
      // sticks stored while unarmed, outputs stay neutral
      8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01,
      // arming byte mid-frame, then a button byte that is ignored
      8'h00, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h80, 8'h7F,
      // full-scale sticks all one way
      8'hAA, 8'h55, 8'h00, 8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h7F
    };
    logic [TICKS_W-1:0] periods[NUM_PHASES];
    periods = '{24'd1, 24'hFFFFFF, 24'd0, 24'd20000,
                TICKS_W'($urandom_range(1, 24'hFFFFFF)),
                TICKS_W'($urandom_range(2, 99999)), TICKS_RESET};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset period
    foreach (directed_bytes[i]) push_byte(directed_bytes[i]);

    // random frames under each period setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_period(periods[p]);
      quiet_phase = (p == 2 || p == 5);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) push_byte(pick_byte());
    end

    wait_idle();
    repeat (2 * DUT_LATENCY) @(posedge clk);
    if (duty_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, duty_expected.size());
      errors++;
    end
    $display("run covered %0d items over %0d period settings, %0d results compared",
             items_sent, settings_used, results_checked);
    $display("input held off for %0d cycles, armed at end: %0b", input_stall_cycles,
             armed_ref);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
